// ===== rtl/core/sorted_key_list_macros.svh =====
// Assertion macros shared by the sorted key list checker.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef SORTED_KEY_LIST_MACROS_SVH
`define SORTED_KEY_LIST_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SKL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication whose consequent starts in the cycle after the antecedent.
`define SKL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/skl_pkg.sv =====
// Package for the sorted key list: sizes, command and status codes, result bundle.
// Used by skl_ctrl, sorted_key_list and skl_checker; depends on nothing.
package skl_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic                    valid;
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key;
        logic                    last;
    } res_t;

endpackage

// ===== rtl/core/skl_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module skl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/skl_ctrl.sv =====
// Sequencer of the sorted key list: scans, shifts and lists the key RAM.
// Depends on skl_pkg; drives the single port of one skl_ram.
module skl_ctrl #(
    parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [1:0]                       cmd,
    input  logic signed [skl_pkg::KEY_W-1:0] key,
    output logic                             idle,
    output logic                             mem_en,
    output logic                             mem_we,
    output logic [$clog2(CAPACITY)-1:0]      mem_addr,
    output logic [skl_pkg::KEY_W-1:0]        mem_wdata,
    input  logic [skl_pkg::KEY_W-1:0]        mem_rdata,
    output skl_pkg::res_t                    res
);

    import skl_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS_RD  = 9'b000000010,
        S_INS_WR  = 9'b000000100,
        S_DEL_RD  = 9'b000001000,
        S_DEL_CMP = 9'b000010000,
        S_SH_RD   = 9'b000100000,
        S_SH_WR   = 9'b001000000,
        S_LST_RD  = 9'b010000000,
        S_LST_OUT = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        idx_dec;
    logic                    idx_at_end;

    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_dec    = idx_reg - CNT_W'(1);
    assign idx_at_end = (idx_inc == count_reg);
    assign idle       = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = idx_reg[ADDR_W-1:0];
        mem_wdata  = key_reg;
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res = '{valid: 1'b1, status: ST_FULL, key: key, last: 1'b1};
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res = '{valid: 1'b1, status: ST_EMPTY, key: key, last: 1'b1};
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DEL_RD;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res = '{valid: 1'b1, status: ST_EMPTY, key: '0, last: 1'b1};
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_LST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Insertion walks down from the top, moving every entry that is not
            // smaller than the new key up by one place.
            S_INS_RD:
            begin
                mem_en = 1'b1;
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    res        = '{valid: 1'b1, status: ST_OK, key: key_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_addr   = idx_dec[ADDR_W-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                if ($signed(mem_rdata) < key_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                    res        = '{valid: 1'b1, status: ST_OK, key: key_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
            end

            S_DEL_RD:
            begin
                mem_en     = 1'b1;
                state_next = S_DEL_CMP;
            end

            S_DEL_CMP:
            begin
                if ($signed(mem_rdata) == key_reg)
                begin
                    state_next = S_SH_RD;
                end
                else if (idx_at_end)
                begin
                    res = '{valid: 1'b1, status: ST_NOT_FOUND, key: key_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
            end

            // The entries above the removed one close the gap one at a time.
            S_SH_RD:
            begin
                if (idx_at_end)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res        = '{valid: 1'b1, status: ST_OK, key: key_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_en     = 1'b1;
                    mem_addr   = idx_inc[ADDR_W-1:0];
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end

            S_LST_RD:
            begin
                mem_en     = 1'b1;
                state_next = S_LST_OUT;
            end

            S_LST_OUT:
            begin
                res = '{valid: 1'b1, status: ST_OK, key: $signed(mem_rdata),
                        last: idx_at_end};
                if (idx_at_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_LST_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sorted_key_list.sv =====
// Top level of the sorted key list: sequencer, key RAM and result register.
// Depends on skl_pkg, skl_ram and skl_ctrl.
//
//  channel   direction  handshake              fields
//  request   in         start high, busy low   cmd, key
//  result    out        strobe, one cycle      status, key_out, last
//
// Insert moves every stored key not smaller than the new one up by one place, delete
// scans from the bottom and closes the gap, list reads the stored keys in turn; a refused or
// empty-table request is answered without leaving idle.
// The single RAM port serves at most one read or one write per cycle.
// Each result appears on the ports in the cycle after the sequencer produces it.
// Reset clears the state, the key count, the index and the strobe; the RAM needs no clearing pass.
// The receiver cannot stall; busy is the only back-pressure on requests.
module sorted_key_list #(
    parameter int CAPACITY = skl_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic signed [skl_pkg::KEY_W-1:0] key,
    output logic                             strobe,
    output logic [1:0]                       status,
    output logic signed [skl_pkg::KEY_W-1:0] key_out,
    output logic                             last
);

    import skl_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              idle;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [KEY_W-1:0]  mem_wdata;
    logic [KEY_W-1:0]  mem_rdata;
    res_t              res;

    logic                    strobe_reg;
    logic [1:0]              status_reg;
    logic signed [KEY_W-1:0] key_out_reg;
    logic                    last_reg;

    skl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .key       (key),
        .idle      (idle),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .res       (res)
    );

    skl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg  <= res.status;
            key_out_reg <= res.key;
            last_reg    <= res.last;
        end
    end

    assign busy    = !idle;
    assign strobe  = strobe_reg;
    assign status  = status_reg;
    assign key_out = key_out_reg;
    assign last    = last_reg;

endmodule

// ===== rtl/core/skl_checker.sv =====
// Port-level checks on the sorted key list, bound to the top level.
// Depends on skl_pkg and sorted_key_list_macros.svh.
`include "sorted_key_list_macros.svh"

module skl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] cmd,
    input logic       strobe,
    input logic [1:0] status,
    input logic       last
);

    import skl_pkg::*;

    // A request with a defined command either starts work or answers at once.
    `SKL_ASSERT_NEXT(a_req_acts, start && !busy && cmd <= CMD_LIST, busy || strobe, "request ignored")

    // Only a listing gives several results, so failures always close the request.
    `SKL_ASSERT_ALWAYS(a_fail_last, !strobe || status == ST_OK || last, "failure not last")

    // Listing results come while the block is still busy, never back to back.
    `SKL_ASSERT_ALWAYS(a_list_busy, !(strobe && !last) || busy, "list result while idle")
    `SKL_ASSERT_NEXT(a_list_gap, strobe && !last, !strobe ##1 strobe, "list results out of step")

endmodule

bind sorted_key_list skl_checker u_skl_checker (.*);
